>>> rtl/fcrt_pkg.sv
// Shared types and constants for the function call/return tracer.
// Used by fcrt_cell and function_call_return_tracer; depends on nothing else.
package fcrt_pkg;

   localparam int ADDR_W  = 64;
   localparam int DEPTH_W = 16;

   localparam int DEFAULT_TABLE_DEPTH = 1024;
   localparam int DEFAULT_MAX_INDENT  = 99;
   localparam int DEFAULT_NUM_CELLS   = 4;

   localparam logic MODE_APPEND = 1'b0;
   localparam logic MODE_JUMP   = 1'b1;

   localparam logic KIND_CALL   = 1'b0;
   localparam logic KIND_RETURN = 1'b1;

   // Per-cell control from the sequencer.
   typedef struct packed {
      logic clear;
      logic rd_en;
      logic wr_en;
   } cell_ctrl_type;

endpackage

>>> rtl/fcrt_cell.sv
// One cell of the tracer chain: a bank of the range table, its range compare,
// and one link of the registered last-match chain. Depends on fcrt_pkg.
module fcrt_cell #(
   parameter int TABLE_DEPTH = fcrt_pkg::DEFAULT_TABLE_DEPTH,
   parameter int NUM_CELLS   = fcrt_pkg::DEFAULT_NUM_CELLS,
   parameter int CELL_ID     = 0,
   localparam int CELL_DEPTH = (TABLE_DEPTH + NUM_CELLS - 1) / NUM_CELLS,
   localparam int LA_W       = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1,
   localparam int IDX_W      = $clog2(TABLE_DEPTH + 1),
   localparam int LINK_W     = 2 + 2 * IDX_W + fcrt_pkg::ADDR_W
) (
   input  logic                        clock,
   input  logic                        reset,
   input  fcrt_pkg::cell_ctrl_type     ctrl,
   input  logic [LA_W-1:0]             scan_addr,
   input  logic [LA_W-1:0]             wr_addr,
   input  logic [fcrt_pkg::ADDR_W-1:0] wr_start,
   input  logic [fcrt_pkg::ADDR_W-1:0] wr_size,
   input  logic [IDX_W-1:0]            entry_count,
   input  logic [fcrt_pkg::ADDR_W-1:0] jump_pc,
   input  logic [fcrt_pkg::ADDR_W-1:0] jump_target,
   input  logic [LINK_W-1:0]           link_in,
   output logic [LINK_W-1:0]           link_out
);
   import fcrt_pkg::*;

   localparam int BASE = CELL_ID * CELL_DEPTH;

   typedef struct packed {
      logic              src_hit;
      logic [IDX_W-1:0]  src_idx;
      logic              dst_hit;
      logic [IDX_W-1:0]  dst_idx;
      logic [ADDR_W-1:0] dst_start;
   } link_type;

   logic [2*ADDR_W-1:0] bank [CELL_DEPTH];

   logic [2*ADDR_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]    rd_idx_ff;
   logic                rd_valid_ff;
   logic                rd_valid_in;
   logic                live;

   logic [ADDR_W-1:0]   rd_start;
   logic [ADDR_W-1:0]   rd_size;
   logic                pc_hit;
   logic                target_hit;

   link_type            own_ff;
   link_type            own_in;
   link_type            link_ff;
   link_type            link_in_s;
   link_type            link_nx_in;

   // Entries at or beyond the fill count are never matched.
   assign live = (32'(BASE) + 32'(scan_addr)) < 32'(entry_count);
   assign rd_valid_in = ctrl.rd_en && live && !ctrl.clear;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         bank[wr_addr] <= {wr_start, wr_size};
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= bank[scan_addr];
      end
      rd_idx_ff <= IDX_W'(BASE) + IDX_W'(scan_addr);
   end

   assign rd_start   = rd_data_ff[2*ADDR_W-1:ADDR_W];
   assign rd_size    = rd_data_ff[ADDR_W-1:0];
   assign pc_hit     = rd_valid_ff && (rd_start <= jump_pc)
                       && ((jump_pc - rd_start) < rd_size);
   assign target_hit = rd_valid_ff && (rd_start <= jump_target)
                       && ((jump_target - rd_start) < rd_size);

   // Scan order is ascending, so a later hit replaces an earlier one.
   always_comb begin
      own_in = own_ff;
      if (pc_hit) begin
         own_in.src_hit = 1'b1;
         own_in.src_idx = rd_idx_ff;
      end
      if (target_hit) begin
         own_in.dst_hit   = 1'b1;
         own_in.dst_idx   = rd_idx_ff;
         own_in.dst_start = rd_start;
      end
      if (ctrl.clear) begin
         own_in = '0;
      end
   end

   // Higher cells hold higher entries, so a hit here wins over the neighbor.
   assign link_in_s = link_type'(link_in);

   always_comb begin
      link_nx_in = link_in_s;
      if (own_ff.src_hit) begin
         link_nx_in.src_hit = 1'b1;
         link_nx_in.src_idx = own_ff.src_idx;
      end
      if (own_ff.dst_hit) begin
         link_nx_in.dst_hit   = 1'b1;
         link_nx_in.dst_idx   = own_ff.dst_idx;
         link_nx_in.dst_start = own_ff.dst_start;
      end
      if (ctrl.clear) begin
         link_nx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         own_ff      <= '0;
         link_ff     <= '0;
      end else begin
         rd_valid_ff <= rd_valid_in;
         own_ff      <= own_in;
         link_ff     <= link_nx_in;
      end
   end

   assign link_out = LINK_W'(link_ff);

endmodule

>>> rtl/function_call_return_tracer.sv
// Function call/return tracer top level. Append items are accepted one per cycle while idle.
// A jump item keeps the sequencer busy through the scan, drain and finish states, and the
// finish state waits for a free output register when there is a result to register.
// Each cell scans its own table bank one entry per cycle, then the match chain settles one
// cell per cycle. Synchronous reset empties the table count, zeroes the call depth and
// idles the sequencer; table contents are kept.
module function_call_return_tracer #(
   parameter int TABLE_DEPTH = fcrt_pkg::DEFAULT_TABLE_DEPTH,
   parameter int MAX_INDENT  = fcrt_pkg::DEFAULT_MAX_INDENT,
   parameter int NUM_CELLS   = fcrt_pkg::DEFAULT_NUM_CELLS,
   localparam int IDX_W      = $clog2(TABLE_DEPTH + 1),
   localparam int IND_W      = $clog2(MAX_INDENT + 1)
) (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_mode,
   input  logic [fcrt_pkg::ADDR_W-1:0] req_entry_start,
   input  logic [fcrt_pkg::ADDR_W-1:0] req_entry_size,
   input  logic [fcrt_pkg::ADDR_W-1:0] req_jump_pc,
   input  logic [fcrt_pkg::ADDR_W-1:0] req_jump_target,
   input  logic                        req_is_call,

   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_event_kind,
   output logic [IDX_W-1:0]            rsp_function_index,
   output logic [fcrt_pkg::ADDR_W-1:0] rsp_function_start,
   output logic [fcrt_pkg::ADDR_W-1:0] rsp_trace_pc,
   output logic [IND_W-1:0]            rsp_indent
);
   import fcrt_pkg::*;

   // The table is split into NUM_CELLS contiguous banks; cell i holds entries
   // i*CELL_DEPTH and up, so the highest cell with a hit has the last match.
   localparam int CELL_DEPTH = (TABLE_DEPTH + NUM_CELLS - 1) / NUM_CELLS;
   localparam int LA_W       = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
   localparam int CW         = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
   localparam int DW         = $clog2(NUM_CELLS + 1);
   localparam int LINK_W     = 2 + 2 * IDX_W + ADDR_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   typedef struct packed {
      logic              src_hit;
      logic [IDX_W-1:0]  src_idx;
      logic              dst_hit;
      logic [IDX_W-1:0]  dst_idx;
      logic [ADDR_W-1:0] dst_start;
   } link_type;

   logic [1:0]         state_ff, state_in;
   logic [IDX_W-1:0]   count_ff, count_in;
   logic [CW-1:0]      wr_cell_ff, wr_cell_in;
   logic [LA_W-1:0]    wr_local_ff, wr_local_in;
   logic [LA_W-1:0]    scan_addr_ff, scan_addr_in;
   logic [DW-1:0]      drain_ff, drain_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;

   logic [ADDR_W-1:0]  pc_ff, pc_in;
   logic [ADDR_W-1:0]  target_ff, target_in;
   logic               call_ff, call_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff, rsp_kind_in;
   logic [IDX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [ADDR_W-1:0]  rsp_start_ff, rsp_start_in;
   logic [ADDR_W-1:0]  rsp_pc_ff, rsp_pc_in;
   logic [IND_W-1:0]   rsp_indent_ff, rsp_indent_in;

   logic               req_fire;
   logic               append_fire;
   logic               jump_fire;

   logic [LINK_W-1:0]  link_w [NUM_CELLS+1];
   link_type           res;
   logic [IDX_W-1:0]   src_v;
   logic [IDX_W-1:0]   dst_v;
   logic               dst_at_start;
   logic               same_entry;
   logic               has_call;
   logic               has_ret;
   logic               out_free;
   logic [IND_W-1:0]   indent_now;

   // Items are taken only while the sequencer is idle; the output register
   // lets a new item in while an earlier result is still waiting.
   assign req_stall   = (state_ff != ST_IDLE);
   assign req_fire    = req_valid && !req_stall;
   assign append_fire = req_fire && (req_mode == MODE_APPEND)
                        && (count_ff < IDX_W'(TABLE_DEPTH));
   assign jump_fire   = req_fire && (req_mode == MODE_JUMP);

   // Cell chain. Cell 0 sees an empty link from the left.
   assign link_w[0] = '0;

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      cell_ctrl_type ctrl;

      assign ctrl.clear = jump_fire;
      assign ctrl.rd_en = (state_ff == ST_SCAN);
      assign ctrl.wr_en = append_fire && (wr_cell_ff == CW'(i));

      fcrt_cell #(
         .TABLE_DEPTH (TABLE_DEPTH),
         .NUM_CELLS   (NUM_CELLS),
         .CELL_ID     (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .scan_addr   (scan_addr_ff),
         .wr_addr     (wr_local_ff),
         .wr_start    (req_entry_start),
         .wr_size     (req_entry_size),
         .entry_count (count_ff),
         .jump_pc     (pc_ff),
         .jump_target (target_ff),
         .link_in     (link_w[i]),
         .link_out    (link_w[i+1])
      );
   end

   // Classification, valid once the chain has settled in ST_FINISH.
   // A missing match carries the index TABLE_DEPTH, so two misses compare equal.
   assign res          = link_type'(link_w[NUM_CELLS]);
   assign src_v        = res.src_hit ? res.src_idx : IDX_W'(TABLE_DEPTH);
   assign dst_v        = res.dst_hit ? res.dst_idx : IDX_W'(TABLE_DEPTH);
   assign same_entry   = (src_v == dst_v);
   assign dst_at_start = res.dst_hit && (res.dst_start == target_ff);
   assign has_call     = !same_entry && dst_at_start && call_ff;
   assign has_ret      = !same_entry && !dst_at_start;
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   // The depth is read as signed; negative depths indent by zero.
   always_comb begin
      if (depth_ff[DEPTH_W-1]) begin
         indent_now = '0;
      end else if (depth_ff > DEPTH_W'(MAX_INDENT)) begin
         indent_now = IND_W'(MAX_INDENT);
      end else begin
         indent_now = depth_ff[IND_W-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      wr_cell_in    = wr_cell_ff;
      wr_local_in   = wr_local_ff;
      scan_addr_in  = scan_addr_ff;
      drain_in      = drain_ff;
      depth_in      = depth_ff;
      pc_in         = pc_ff;
      target_in     = target_ff;
      call_in       = call_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_kind_in   = rsp_kind_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_pc_in     = rsp_pc_ff;
      rsp_indent_in = rsp_indent_ff;

      // Appends past a full table are accepted and dropped.
      if (append_fire) begin
         count_in = count_ff + IDX_W'(1);
         if (wr_local_ff == LA_W'(CELL_DEPTH - 1)) begin
            wr_local_in = '0;
            wr_cell_in  = wr_cell_ff + CW'(1);
         end else begin
            wr_local_in = wr_local_ff + LA_W'(1);
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (jump_fire) begin
               pc_in        = req_jump_pc;
               target_in    = req_jump_target;
               call_in      = req_is_call;
               scan_addr_in = '0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_addr_ff == LA_W'(CELL_DEPTH - 1)) begin
               drain_in = '0;
               state_in = ST_DRAIN;
            end else begin
               scan_addr_in = scan_addr_ff + LA_W'(1);
            end
         end
         ST_DRAIN: begin
            // Covers the last compare, then the settling of each cell of the chain.
            if (drain_ff == DW'(NUM_CELLS)) begin
               state_in = ST_FINISH;
            end else begin
               drain_in = drain_ff + DW'(1);
            end
         end
         ST_FINISH: begin
            if (!(has_call || has_ret)) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_pc_in     = pc_ff;
               rsp_indent_in = indent_now;
               if (has_call) begin
                  rsp_kind_in  = KIND_CALL;
                  rsp_index_in = dst_v;
                  rsp_start_in = res.dst_start;
                  depth_in     = depth_ff + DEPTH_W'(1);
               end else begin
                  rsp_kind_in  = KIND_RETURN;
                  rsp_index_in = src_v;
                  rsp_start_in = '0;
                  depth_in     = depth_ff - DEPTH_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         wr_cell_ff   <= '0;
         wr_local_ff  <= '0;
         scan_addr_ff <= '0;
         drain_ff     <= '0;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         wr_cell_ff   <= wr_cell_in;
         wr_local_ff  <= wr_local_in;
         scan_addr_ff <= scan_addr_in;
         drain_ff     <= drain_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pc_ff         <= pc_in;
      target_ff     <= target_in;
      call_ff       <= call_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_pc_ff     <= rsp_pc_in;
      rsp_indent_ff <= rsp_indent_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_kind     = rsp_kind_ff;
   assign rsp_function_index = rsp_index_ff;
   assign rsp_function_start = rsp_start_ff;
   assign rsp_trace_pc       = rsp_pc_ff;
   assign rsp_indent         = rsp_indent_ff;

endmodule

>>> tb/fcrt_trace_monitor.sv
`timescale 1ns / 1ps
// Watches both channels of function_call_return_tracer and checks the traced events it reports.
// Depends on fcrt_pkg for the mode and event kind codes; hands its error count to the top.
module fcrt_trace_monitor #(
   parameter int TABLE_DEPTH = fcrt_pkg::DEFAULT_TABLE_DEPTH,
   parameter int MAX_INDENT  = fcrt_pkg::DEFAULT_MAX_INDENT,
   localparam int IDX_W      = $clog2(TABLE_DEPTH + 1),
   localparam int IND_W      = $clog2(MAX_INDENT + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic              req_mode,
   input  logic [63:0]       req_entry_start,
   input  logic [63:0]       req_entry_size,
   input  logic [63:0]       req_jump_pc,
   input  logic [63:0]       req_jump_target,
   input  logic              req_is_call,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic              rsp_event_kind,
   input  logic [IDX_W-1:0]  rsp_function_index,
   input  logic [63:0]       rsp_function_start,
   input  logic [63:0]       rsp_trace_pc,
   input  logic [IND_W-1:0]  rsp_indent,
   output int                error_count,
   output int                pending
);
   import fcrt_pkg::*;

   typedef struct {
      logic             kind;
      logic [IDX_W-1:0] index;
      logic [63:0]      start;
      logic [63:0]      pc;
      logic [IND_W-1:0] indent;
   } trace_event_type;

   logic [63:0]     range_start [TABLE_DEPTH];
   logic [63:0]     range_size [TABLE_DEPTH];
   int              loaded_count;
   logic [15:0]     call_depth;
   trace_event_type expected_events[$];

   // A range holds an address when it lies in [start, start + size) without wraparound.
   function automatic bit range_holds(int i, logic [63:0] addr);
      return range_start[i] <= addr && (addr - range_start[i]) < range_size[i];
   endfunction

   function automatic logic [IND_W-1:0] indent_now();
      if (call_depth[15])
         return '0;
      if (call_depth > MAX_INDENT)
         return IND_W'(MAX_INDENT);
      return call_depth[IND_W-1:0];
   endfunction

   task automatic trace_item(input logic mode, input logic [63:0] new_start,
                             input logic [63:0] new_size, input logic [63:0] pc,
                             input logic [63:0] target, input logic call);
      int              src;
      int              dst;
      trace_event_type ev;
      if (mode == MODE_APPEND) begin
         if (loaded_count < TABLE_DEPTH) begin
            range_start[loaded_count] = new_start;
            range_size[loaded_count] = new_size;
            loaded_count++;
         end
      end else begin
         src = TABLE_DEPTH;
         dst = TABLE_DEPTH;
         for (int i = 0; i < loaded_count; i++) begin
            if (range_holds(i, pc))
               src = i;
            if (range_holds(i, target))
               dst = i;
         end
         ev.pc = pc;
         ev.indent = indent_now();
         if (src != dst) begin
            if (dst != TABLE_DEPTH && range_start[dst] == target) begin
               // A jump onto a function's first byte is only a call for call forms.
               if (call) begin
                  ev.kind = KIND_CALL;
                  ev.index = IDX_W'(dst);
                  ev.start = target;
                  expected_events.push_back(ev);
                  call_depth = call_depth + 16'd1;
               end
            end else begin
               ev.kind = KIND_RETURN;
               ev.index = IDX_W'(src);
               ev.start = '0;
               expected_events.push_back(ev);
               call_depth = call_depth - 16'd1;
            end
         end
      end
   endtask

   task automatic check_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
         error_count++;
      end
   endtask

   task automatic check_event();
      trace_event_type want;
      if (expected_events.size() == 0) begin
         $display("%0t: unexpected event: expected none, got kind %0d index %0d pc %h",
                  $time, rsp_event_kind, rsp_function_index, rsp_trace_pc);
         error_count++;
      end else begin
         want = expected_events.pop_front();
         check_field("event_kind", want.kind, rsp_event_kind);
         check_field("function_index", want.index, rsp_function_index);
         check_field("function_start", want.start, rsp_function_start);
         check_field("trace_pc", want.pc, rsp_trace_pc);
         check_field("indent", want.indent, rsp_indent);
      end
   endtask

   // Results are checked before new items are traced, since a result seen at
   // the same edge always belongs to an earlier item.
   always @(posedge clock) begin
      if (reset) begin
         loaded_count = 0;
         call_depth = '0;
         expected_events.delete();
      end else begin
         if (rsp_valid && !rsp_stall)
            check_event();
         if (req_valid && !req_stall)
            trace_item(req_mode, req_entry_start, req_entry_size, req_jump_pc,
                       req_jump_target, req_is_call);
      end
      pending <= expected_events.size();
   end

endmodule

>>> tb/function_call_return_tracer_tb.sv
`timescale 1ns / 1ps
// Stimulus and verdict for function_call_return_tracer: loads function ranges and sends jumps.
// Depends on fcrt_pkg, the block itself and fcrt_trace_monitor, which does all the checking.
module function_call_return_tracer_tb;
   import fcrt_pkg::*;

   localparam int TABLE_DEPTH = DEFAULT_TABLE_DEPTH;
   localparam int MAX_INDENT  = DEFAULT_MAX_INDENT;
   localparam int IDX_W       = $clog2(TABLE_DEPTH + 1);
   localparam int IND_W       = $clog2(MAX_INDENT + 1);

   // Address map of the stimulus. Well-formed functions sit one per 4 KiB page
   // from FUNC_BASE, so they never overlap one another. FREE_BASE is a region
   // that no deliberate entry covers and ZERO_SIZE_AT holds an entry of size zero.
   localparam logic [63:0] FUNC_BASE    = 64'h0000_0000_4000_0000;
   localparam logic [63:0] FREE_BASE    = 64'h0000_7000_0000_0000;
   localparam logic [63:0] ZERO_SIZE_AT = 64'h0000_6000_0000_0000;
   localparam logic [63:0] TOP_START    = 64'hFFFF_FFFF_FFFF_F000;
   localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

   // Extra wait after the final drain, for any result still in flight.
   localparam int SETTLE_CYCLES = 300;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic              req_mode;
   logic [63:0]       req_entry_start;
   logic [63:0]       req_entry_size;
   logic [63:0]       req_jump_pc;
   logic [63:0]       req_jump_target;
   logic              req_is_call;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_event_kind;
   logic [IDX_W-1:0]  rsp_function_index;
   logic [63:0]       rsp_function_start;
   logic [63:0]       rsp_trace_pc;
   logic [IND_W-1:0]  rsp_indent;

   int error_count;
   int pending;

   // Stimulus bookkeeping: where the well-formed functions and the nested
   // entries start.
   logic [63:0] fn_start[$];
   logic [63:0] fn_size[$];
   logic [63:0] nest_start[$];

   // While set, the sender leaves no idle cycles and the receiver starts no new stall.
   bit quiet_req = 1'b0;
   bit quiet_rsp = 1'b0;

   int          stall_left = 0;
   int unsigned stall_pick;

   always #1 clock = ~clock;

   function_call_return_tracer #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .MAX_INDENT  (MAX_INDENT)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_entry_start    (req_entry_start),
      .req_entry_size     (req_entry_size),
      .req_jump_pc        (req_jump_pc),
      .req_jump_target    (req_jump_target),
      .req_is_call        (req_is_call),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_function_index (rsp_function_index),
      .rsp_function_start (rsp_function_start),
      .rsp_trace_pc       (rsp_trace_pc),
      .rsp_indent         (rsp_indent)
   );

   fcrt_trace_monitor #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .MAX_INDENT  (MAX_INDENT)
   ) trace_monitor (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_entry_start    (req_entry_start),
      .req_entry_size     (req_entry_size),
      .req_jump_pc        (req_jump_pc),
      .req_jump_target    (req_jump_target),
      .req_is_call        (req_is_call),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_function_index (rsp_function_index),
      .rsp_function_start (rsp_function_start),
      .rsp_trace_pc       (rsp_trace_pc),
      .rsp_indent         (rsp_indent),
      .error_count        (error_count),
      .pending            (pending)
   );

   // The receiver stalls in runs: mostly open stretches, some short stalls and
   // now and then a long one, so that stalls land on every phase of a jump.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_pick = $urandom_range(0, 99);
         if (quiet_rsp || stall_pick < 55) begin
            rsp_stall <= 1'b0;
            stall_left = $urandom_range(1, 20);
         end else if (stall_pick < 92) begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(1, 3);
         end else begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(20, 60);
         end
      end else begin
         stall_left--;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Idle cycles the sender leaves after an item: mostly none, some short and
   // a few long gaps.
   function automatic int sender_gap();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (quiet_req || pick < 65)
         return 0;
      if (pick < 92)
         return $urandom_range(1, 4);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [63:0] addr_in_fn(int k);
      return fn_start[k] + $urandom_range(0, fn_size[k][31:0] - 1);
   endfunction

   function automatic logic [63:0] free_addr();
      return FREE_BASE + $urandom_range(0, 32'hFFFF_FFF0);
   endfunction

   function automatic int pick_fn();
      return $urandom_range(0, fn_start.size() - 1);
   endfunction

   // Presents one item and holds it until the block takes it. Valid stays high
   // into the next item when no gap follows.
   task automatic send_item(input logic mode, input logic [63:0] new_start,
                            input logic [63:0] new_size, input logic [63:0] pc,
                            input logic [63:0] target, input logic call);
      int gap;
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_entry_start <= new_start;
      req_entry_size  <= new_size;
      req_jump_pc     <= pc;
      req_jump_target <= target;
      req_is_call     <= call;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Fields that the mode does not use carry random values, since the block
   // must ignore them.
   task automatic append_entry(input logic [63:0] new_start, input logic [63:0] new_size);
      send_item(MODE_APPEND, new_start, new_size, rand64(), rand64(), 1'($urandom_range(0, 1)));
   endtask

   task automatic jump_item(input logic [63:0] pc, input logic [63:0] target,
                            input logic call);
      send_item(MODE_JUMP, rand64(), rand64(), pc, target, call);
   endtask

   task automatic add_function();
      logic [63:0] fn_base;
      logic [63:0] fn_bytes;
      fn_base  = FUNC_BASE + 64'(fn_start.size()) * 64'h1000;
      fn_bytes = 64'($urandom_range(32'h100, 32'hFFF));
      fn_start.push_back(fn_base);
      fn_size.push_back(fn_bytes);
      append_entry(fn_base, fn_bytes);
   endtask

   // A small entry inside a function, away from its first byte. Being loaded
   // later, it wins over the enclosing function for addresses it holds.
   task automatic add_nested();
      logic [63:0] inner;
      inner = fn_start[pick_fn()] + $urandom_range(32'h10, 32'h80);
      nest_start.push_back(inner);
      append_entry(inner, 64'($urandom_range(32'h10, 32'h60)));
   endtask

   // Entries at arbitrary addresses. The ones near the top of the address space
   // get a full random size, which exercises the range end without wraparound.
   task automatic add_noise();
      if ($urandom_range(0, 2) == 0)
         append_entry(64'hFFFF_FFFF_FFFF_0000 | 64'($urandom_range(0, 32'hFFFF)), rand64());
      else
         append_entry(rand64(), 64'($urandom_range(1, 32'hFFFF)));
   endtask

   // A jump mostly from inside a known function, landing on a function start,
   // inside a function, in its own function, in free space, anywhere at all or on a nested entry.
   task automatic random_jump();
      int unsigned pick;
      int          k;
      logic [63:0] pc;
      logic [63:0] target;
      logic        call;
      k = pick_fn();
      pick = $urandom_range(0, 99);
      if (pick < 85)
         pc = addr_in_fn(k);
      else if (pick < 90)
         pc = free_addr();
      else if (pick < 95)
         pc = rand64();
      else if (pick[0])
         pc = ALL_ONES - $urandom_range(0, 255);
      else
         pc = 64'($urandom_range(0, 255));
      call = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         target = fn_start[pick_fn()];
         call = ($urandom_range(0, 9) != 0);
      end else if (pick < 70) begin
         target = addr_in_fn(pick_fn());
      end else if (pick < 78) begin
         target = addr_in_fn(k);
      end else if (pick < 85) begin
         target = free_addr();
      end else if (pick < 93) begin
         target = rand64();
      end else if (nest_start.size() > 0) begin
         target = nest_start[$urandom_range(0, nest_start.size() - 1)];
      end else begin
         target = fn_start[k];
      end
      jump_item(pc, target, call);
   endtask

   task automatic random_item();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 85)
         random_jump();
      else if (pick < 92)
         add_function();
      else if (pick < 96)
         add_nested();
      else
         add_noise();
   endtask

   // Stops sending and waits until every expected result has come. The first
   // edge lets the monitor account for an item taken at the current edge.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
   endtask

   initial begin
      int a;
      int b;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_mode        = MODE_APPEND;
      req_entry_start = '0;
      req_entry_size  = '0;
      req_jump_pc     = '0;
      req_jump_target = '0;
      req_is_call     = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part. A jump on an empty table matches nothing on either
      // side, which counts as the same entry and gives no result.
      jump_item(64'h1000, 64'h2000, 1'b1);

      // Four functions, then the extremes: an entry at address zero, one at
      // the top whose size would wrap, one of size zero and a nested entry.
      repeat (4) add_function();
      append_entry(64'h0, 64'h800);
      append_entry(TOP_START, ALL_ONES);
      append_entry(ZERO_SIZE_AT, 64'h0);
      nest_start.push_back(fn_start[1] + 64'h40);
      append_entry(fn_start[1] + 64'h40, 64'h40);

      // Returns first, so the depth goes negative and the indent stays zero.
      jump_item(addr_in_fn(0), fn_start[1] + 64'h10, 1'b1);
      jump_item(addr_in_fn(0), free_addr(), 1'b0);
      // A return from a source that matches no entry.
      jump_item(free_addr(), fn_start[2] + 64'h8, 1'b1);
      // Both ends in the same function: no result.
      jump_item(fn_start[0], fn_start[0] + 64'h20, 1'b1);
      // Landing on a function start without a call form: no result.
      jump_item(addr_in_fn(0), fn_start[2], 1'b0);
      // Calls into a plain function, a nested entry and the entry at zero.
      jump_item(addr_in_fn(0), fn_start[3], 1'b1);
      jump_item(fn_start[2] + 64'h4, fn_start[1] + 64'h40, 1'b1);
      jump_item(addr_in_fn(3), 64'h0, 1'b1);
      // The last address of the space lies in the top entry.
      jump_item(ALL_ONES, fn_start[0], 1'b1);
      jump_item(addr_in_fn(0), ALL_ONES, 1'b1);
      // The size-zero entry never matches, so this is a plain return.
      jump_item(addr_in_fn(1), ZERO_SIZE_AT, 1'b1);

      // Random mix of jumps and new entries.
      repeat (150) random_item();

      // Hold off until everything in flight has been reported.
      drain();

      // A long chain of calls with no idle cycles on either side drives the
      // depth past the indent limit, then returns walk it back down.
      quiet_req = 1'b1;
      quiet_rsp = 1'b1;
      repeat (115) begin
         a = pick_fn();
         b = (a + 1 + $urandom_range(0, fn_start.size() - 2)) % fn_start.size();
         jump_item(addr_in_fn(a), fn_start[b], 1'b1);
      end
      quiet_req = 1'b0;
      quiet_rsp = 1'b0;
      repeat (40) begin
         a = pick_fn();
         b = (a + 1 + $urandom_range(0, fn_start.size() - 2)) % fn_start.size();
         jump_item(addr_in_fn(a), fn_start[b] + 64'h8, 1'($urandom_range(0, 1)));
      end

      repeat (150) random_item();

      repeat (100) random_jump();

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("function_call_return_tracer_tb: done, clean");
      else
         $display("function_call_return_tracer_tb: done, errors");
      $finish;
   end

   // Watchdog: a hung handshake or a result that never comes ends here.
   initial begin
      #2_400_000;
      $display("function_call_return_tracer_tb: done, errors");
      $finish;
   end

endmodule
